FILE: hw/rtl/sam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

	// request action codes
	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_APPEND = 3'd1;
	localparam logic [2:0] ACT_XLATE  = 3'd2;
	localparam logic [2:0] ACT_ADDR   = 3'd3;
	localparam logic [2:0] ACT_FIND   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// fixed field widths
	localparam int unsigned ACT_W  = 3;
	localparam int unsigned NUM_W  = 8;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned NAME_W = 64;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned SEC_W  = 7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sam_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sam_req_if;
	logic                              valid;
	logic                              ready;
	logic [sam_pkg::ACT_W-1:0]         action;
	logic [sam_pkg::NUM_W-1:0]         section_number;
	logic [sam_pkg::ADDR_W-1:0]        section_offset;
	logic [sam_pkg::ADDR_W-1:0]        lookup_rva;
	logic [sam_pkg::ADDR_W-1:0]        section_base;
	logic [sam_pkg::NAME_W-1:0]        section_name;

	modport source (
		output valid, action, section_number, section_offset, lookup_rva,
			section_base, section_name,
		input  ready
	);
	modport sink (
		input  valid, action, section_number, section_offset, lookup_rva,
			section_base, section_name,
		output ready
	);
endinterface

interface sam_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sam_pkg::STAT_W-1:0]        status;
	logic [sam_pkg::ADDR_W-1:0]        rva_result;
	logic [sam_pkg::SEC_W-1:0]         section_result;
	logic [sam_pkg::ADDR_W-1:0]        offset_result;

	modport source (
		output valid, status, rva_result, section_result, offset_result,
		input  ready
	);
	modport sink (
		input  valid, status, rva_result, section_result, offset_result,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/section_address_map.sv
`timescale 1ns / 1ps
`default_nettype none

// section address map: holds up to MAX_SECTIONS image sections (32-bit base and
// 8-byte name) in two single-port-read memories and answers one request at a
// time. clear, append, an invalid number and a query on an empty table go
// straight to the result; number+offset translation does one memory read,
// then uses the shared 32-bit adder; address and name lookups scan the
// table, reading one table entry per cycle through the registered memory
// read port. the request side is ready only while the sequencer is idle; a
// finished result sits in an output register, so the next request is taken
// while that result still waits.
module section_address_map #(
	parameter int unsigned MAX_SECTIONS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sam_req_if.sink    req,
	sam_rsp_if.source  rsp
);

	// index into the tables and width of the fill count
	localparam int unsigned IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);

	// names match when equal up to and including the first zero byte
	function automatic logic name_match(
		input logic [sam_pkg::NAME_W-1:0] a,
		input logic [sam_pkg::NAME_W-1:0] b
	);
		logic match;
		logic live;
		match = 1'b1;
		live  = 1'b1;
		for (int k = 0; k < 8; k++) begin
			if (live) begin
				if (a[8*k +: 8] != b[8*k +: 8]) begin
					match = 1'b0;
					live  = 1'b0;
				end else if (a[8*k +: 8] == 8'd0) begin
					live = 1'b0;
				end
			end
		end
		return match;
	endfunction

	sam_pkg::state_t state_q, state_d;

	// control state
	logic [CW-1:0]                 count_q;
	logic [IW-1:0]                 chk_q;
	logic                          found_q;
	logic                          out_valid_q;

	// captured request and scan results
	logic [sam_pkg::ACT_W-1:0]     action_q;
	logic [sam_pkg::ADDR_W-1:0]    offset_q;
	logic [sam_pkg::ADDR_W-1:0]    rva_q;
	logic [sam_pkg::NAME_W-1:0]    name_q;
	logic [sam_pkg::ADDR_W-1:0]    best_base_q;
	logic [IW-1:0]                 best_idx_q;

	// output register
	logic [sam_pkg::STAT_W-1:0]    status_q;
	logic [sam_pkg::ADDR_W-1:0]    rva_res_q;
	logic [sam_pkg::SEC_W-1:0]     sec_res_q;
	logic [sam_pkg::ADDR_W-1:0]    off_res_q;

	logic                          accept;
	logic                          load_out;
	logic                          ram_we;
	logic                          full;
	logic                          num_ok;
	logic                          last;
	logic                          hit;
	logic [sam_pkg::NUM_W-1:0]     num_m1;
	logic [IW-1:0]                 chk_nxt;
	logic [IW-1:0]                 rd_addr;
	logic [sam_pkg::ADDR_W-1:0]    rd_base;
	logic [sam_pkg::NAME_W-1:0]    rd_name;

	// shared adder and result selection
	logic [sam_pkg::ADDR_W-1:0]    add_a;
	logic [sam_pkg::ADDR_W-1:0]    add_b;
	logic [sam_pkg::ADDR_W-1:0]    add_sum;
	logic [sam_pkg::NUM_W-1:0]     sec8;
	logic [sam_pkg::STAT_W-1:0]    status_d;
	logic [sam_pkg::ADDR_W-1:0]    rva_res_d;
	logic [sam_pkg::SEC_W-1:0]     sec_res_d;
	logic [sam_pkg::ADDR_W-1:0]    off_res_d;

	assign accept  = req.valid && req.ready;
	assign full    = (count_q >= CW'(MAX_SECTIONS));
	assign num_ok  = (req.section_number != '0) &&
		(req.section_number <= sam_pkg::NUM_W'(count_q));
	assign num_m1  = req.section_number - sam_pkg::NUM_W'(1);
	assign chk_nxt = chk_q + IW'(1);
	assign last    = (CW'(chk_q) == count_q - CW'(1));

	// idle: prefetch the entry a translation names, else entry 0 for a scan
	// scanning: fetch one ahead of the entry being checked
	always_comb begin
		if (state_q == sam_pkg::S_IDLE) begin
			rd_addr = (req.action == sam_pkg::ACT_XLATE) ? num_m1[IW-1:0] : '0;
		end else begin
			rd_addr = chk_nxt;
		end
	end

	sam_ram #(
		.WIDTH (sam_pkg::ADDR_W),
		.DEPTH (MAX_SECTIONS)
	) u_base_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (req.section_base),
		.rd_addr (rd_addr),
		.rd_data (rd_base)
	);

	sam_ram #(
		.WIDTH (sam_pkg::NAME_W),
		.DEPTH (MAX_SECTIONS)
	) u_name_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (req.section_name),
		.rd_addr (rd_addr),
		.rd_data (rd_name)
	);

	// nearest base at or below the address: a strictly larger base means a
	// smaller offset, so equal bases keep the lower index
	always_comb begin
		if (action_q == sam_pkg::ACT_ADDR) begin
			hit = (rva_q >= rd_base) && (!found_q || (rd_base > best_base_q));
		end else begin
			hit = !found_q && name_match(name_q, rd_name);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sam_pkg::S_IDLE: begin
				if (accept) begin
					if (req.action == sam_pkg::ACT_XLATE && num_ok) begin
						state_d = sam_pkg::S_READ;
					end else if ((req.action == sam_pkg::ACT_ADDR ||
						req.action == sam_pkg::ACT_FIND) && count_q != '0) begin
						state_d = sam_pkg::S_SCAN;
					end else begin
						state_d = sam_pkg::S_DONE;
					end
				end
			end
			sam_pkg::S_READ: begin
				state_d = sam_pkg::S_DONE;
			end
			sam_pkg::S_SCAN: begin
				if (last) begin
					state_d = sam_pkg::S_DONE;
				end
			end
			sam_pkg::S_DONE: begin
				if (load_out) begin
					state_d = sam_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sam_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = (state_q == sam_pkg::S_IDLE);
		load_out  = (state_q == sam_pkg::S_DONE) && (!out_valid_q || rsp.ready);
		ram_we    = accept && (req.action == sam_pkg::ACT_APPEND) && !full;
	end

	// one adder: base + offset for translation, rva - base for address lookup
	always_comb begin
		if (action_q == sam_pkg::ACT_ADDR) begin
			add_a = rva_q;
			add_b = ~best_base_q;
		end else begin
			add_a = best_base_q;
			add_b = offset_q;
		end
		add_sum = add_a + add_b + sam_pkg::ADDR_W'(action_q == sam_pkg::ACT_ADDR);
	end

	assign sec8 = sam_pkg::NUM_W'(best_idx_q) + sam_pkg::NUM_W'(1);

	// result fields from the finished request
	always_comb begin
		status_d  = sam_pkg::ST_OK;
		rva_res_d = '0;
		sec_res_d = '0;
		off_res_d = '0;
		unique case (action_q)
			sam_pkg::ACT_CLEAR: begin
				status_d = sam_pkg::ST_OK;
			end
			sam_pkg::ACT_APPEND: begin
				status_d = found_q ? sam_pkg::ST_OK : sam_pkg::ST_FULL;
			end
			sam_pkg::ACT_XLATE: begin
				if (found_q) begin
					rva_res_d = add_sum;
				end else begin
					status_d  = sam_pkg::ST_MISS;
					rva_res_d = '1;
				end
			end
			sam_pkg::ACT_ADDR: begin
				if (found_q) begin
					sec_res_d = sec8[sam_pkg::SEC_W-1:0];
					off_res_d = add_sum;
				end else begin
					status_d = sam_pkg::ST_MISS;
				end
			end
			sam_pkg::ACT_FIND: begin
				if (found_q) begin
					sec_res_d = sec8[sam_pkg::SEC_W-1:0];
				end else begin
					status_d = sam_pkg::ST_MISS;
				end
			end
			default: begin
				status_d = sam_pkg::ST_MISS;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sam_pkg::S_IDLE;
			count_q     <= '0;
			chk_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sam_pkg::S_IDLE: begin
					if (accept) begin
						chk_q <= '0;
						unique case (req.action)
							sam_pkg::ACT_CLEAR: begin
								count_q <= '0;
								found_q <= 1'b0;
							end
							sam_pkg::ACT_APPEND: begin
								found_q <= !full;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							sam_pkg::ACT_XLATE: begin
								found_q <= num_ok;
							end
							default: begin
								found_q <= 1'b0;
							end
						endcase
					end
				end
				sam_pkg::S_SCAN: begin
					chk_q <= chk_nxt;
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			offset_q <= req.section_offset;
			rva_q    <= req.lookup_rva;
			name_q   <= req.section_name;
		end
		if (state_q == sam_pkg::S_READ) begin
			best_base_q <= rd_base;
		end
		if (state_q == sam_pkg::S_SCAN && hit) begin
			best_base_q <= rd_base;
			best_idx_q  <= chk_q;
		end
		if (load_out) begin
			status_q  <= status_d;
			rva_res_q <= rva_res_d;
			sec_res_q <= sec_res_d;
			off_res_q <= off_res_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.rva_result     = rva_res_q;
	assign rsp.section_result = sec_res_q;
	assign rsp.offset_result  = off_res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sam_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sam_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic [AW-1:0]         rd_addr,
	output      logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: tb/section_address_map_checker.sv
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the section table and
// compares every response with the oldest expected answer
module section_address_map_checker
	import sam_pkg::*;
#(
	parameter int unsigned MAX_SECTIONS = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sam_req_if          req,
	sam_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] rva_result;
		logic [SEC_W-1:0]  section_result;
		logic [ADDR_W-1:0] offset_result;
	} answer_t;

	answer_t           answer_q[$];
	answer_t           head;
	logic [ADDR_W-1:0] base_mem[MAX_SECTIONS];
	logic [NAME_W-1:0] name_mem[MAX_SECTIONS];
	int unsigned       n_sections;

	initial begin
		fail_count = 0;
		checked    = 0;
		n_sections = 0;
	end

	// byte compare that stops after the first zero byte
	function automatic bit names_equal(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
		for (int k = 0; k < 8; k++) begin
			if (a[8*k +: 8] != b[8*k +: 8])
				return 1'b0;
			if (a[8*k +: 8] == 8'h00)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// applies one request to the table copy and returns its answer
	function automatic answer_t resolve_request(
		input logic [ACT_W-1:0]  act,
		input logic [NUM_W-1:0]  num,
		input logic [ADDR_W-1:0] ofs,
		input logic [ADDR_W-1:0] rva,
		input logic [ADDR_W-1:0] base,
		input logic [NAME_W-1:0] nm
	);
		answer_t           a;
		bit                found;
		logic [ADDR_W-1:0] span;
		a     = '0;
		found = 1'b0;
		case (act)
		ACT_CLEAR: begin
			n_sections = 0;
		end
		ACT_APPEND: begin
			if (n_sections >= MAX_SECTIONS) begin
				a.status = ST_FULL;
			end else begin
				base_mem[n_sections] = base;
				name_mem[n_sections] = nm;
				n_sections++;
			end
		end
		ACT_XLATE: begin
			if (num == 0 || num > n_sections || num > MAX_SECTIONS) begin
				a.status     = ST_MISS;
				a.rva_result = '1;
			end else begin
				a.rva_result = base_mem[num - 1] + ofs;
			end
		end
		ACT_ADDR: begin
			for (int unsigned i = 0; i < n_sections && i < MAX_SECTIONS; i++) begin
				if (rva >= base_mem[i]) begin
					span = rva - base_mem[i];
					if (!found || span < a.offset_result) begin
						found            = 1'b1;
						a.offset_result  = span;
						a.section_result = SEC_W'(i + 1);
					end
				end
			end
			if (!found)
				a.status = ST_MISS;
		end
		ACT_FIND: begin
			a.status = ST_MISS;
			for (int unsigned i = 0; i < n_sections && i < MAX_SECTIONS; i++) begin
				if (names_equal(nm, name_mem[i])) begin
					a.status         = ST_OK;
					a.section_result = SEC_W'(i + 1);
					break;
				end
			end
		end
		default: begin
			a.status = ST_MISS;
		end
		endcase
		return a;
	endfunction

	task automatic check_field(input string fname, input logic [ADDR_W-1:0] exp_v,
		input logic [ADDR_W-1:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_q.delete();
			n_sections = 0;
			pending <= 0;
		end else begin
			// response side first, a response never belongs to the request of the same edge
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (answer_q.size() == 0) begin
					fail_count++;
					$error("response with no request waiting: status %0d rva 0x%0h",
						rsp.status, rsp.rva_result);
				end else begin
					head = answer_q.pop_front();
					check_field("status", ADDR_W'(head.status), ADDR_W'(rsp.status));
					check_field("rva_result", head.rva_result, rsp.rva_result);
					check_field("section_result", ADDR_W'(head.section_result),
						ADDR_W'(rsp.section_result));
					check_field("offset_result", head.offset_result, rsp.offset_result);
				end
			end
			if (req.valid && req.ready)
				answer_q.push_back(resolve_request(req.action, req.section_number,
					req.section_offset, req.lookup_rva, req.section_base, req.section_name));
			pending <= answer_q.size();
		end
	end

endmodule

FILE: tb/section_address_map_tb.sv
`timescale 1ns / 1ps

// top of the section address map bench: makes requests, paces responses and
// gives the verdict; all prediction and comparison lives in the checker
module section_address_map_tb;
	import sam_pkg::*;

	localparam int unsigned MAX_SECTIONS  = 64;
	localparam int unsigned RANDOM_ITEMS  = 1300;
	localparam int unsigned MAX_GAP       = 17;
	// idle-cycle limit; far above a full scan plus both stalls and the hold-off
	localparam int unsigned IDLE_LIMIT    = 5000;
	// one long response hold-off, taken after this many responses
	localparam int unsigned HOLD_AT       = 250;
	localparam int unsigned HOLD_CYCLES   = 600;
	// tail after the last response, longer than a full table scan
	localparam int unsigned TAIL_CYCLES   = MAX_SECTIONS + 40;
	// action codes the block does not implement
	localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sam_req_if req_ch();
	sam_rsp_if rsp_ch();

	section_address_map #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;

	section_address_map_checker #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	// stimulus-side view of the table, used only to aim queries at real entries
	logic [ADDR_W-1:0] sh_base[MAX_SECTIONS];
	logic [NAME_W-1:0] sh_name[MAX_SECTIONS];
	int unsigned       sh_n;

	int unsigned sent;
	int unsigned act_count[8];
	int unsigned full_appends;
	int unsigned fill_sessions;
	bit          tx_quiet;
	bit          rx_quiet;
	bit          held;
	int unsigned rx_count;
	int unsigned idle_cycles;

	// name from a short string, first character in the low byte
	function automatic logic [NAME_W-1:0] str_name(input string s);
		logic [NAME_W-1:0] r;
		r = '0;
		for (int k = 0; k < s.len() && k < 8; k++)
			r[8*k +: 8] = s[k];
		return r;
	endfunction

	// bytes after the terminating zero take no part in a match, so fill them with junk
	function automatic logic [NAME_W-1:0] scramble_tail(input logic [NAME_W-1:0] nm);
		bit hit;
		hit = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (hit)
				nm[8*k +: 8] = 8'($urandom);
			else if (nm[8*k +: 8] == 8'h00)
				hit = 1'b1;
		end
		return nm;
	endfunction

	// bases: random, repeats of existing ones (ties), page-aligned, extremes
	function automatic logic [ADDR_W-1:0] pick_base();
		case ($urandom_range(0, 5))
		0: return $urandom;
		1: return (sh_n > 0) ? sh_base[$urandom_range(0, sh_n - 1)] : '0;
		2: return ADDR_W'($urandom_range(0, 64)) << 12;
		3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		default: return {4'h0, 16'($urandom), 12'h000};
		endcase
	endfunction

	// names: duplicates, full random bytes, empty, and short zero-terminated
	function automatic logic [NAME_W-1:0] pick_name();
		logic [NAME_W-1:0] nm;
		int unsigned       len;
		nm = {$urandom, $urandom};
		case ($urandom_range(0, 5))
		0: begin
			if (sh_n > 0)
				nm = sh_name[$urandom_range(0, sh_n - 1)];
		end
		1: ;
		2: nm = '0;
		default: begin
			len = $urandom_range(0, 7);
			for (int k = 0; k < 8; k++) begin
				if (k < len)
					nm[8*k +: 8] = 8'($urandom_range(1, 255));
				else if (k == len)
					nm[8*k +: 8] = 8'h00;
			end
		end
		endcase
		return nm;
	endfunction

	// one request: optional idle gap, then hold valid until the block takes it.
	// valid is either kept high or lowered here, never both in one step
	task automatic send_item(
		input logic [ACT_W-1:0]  act,
		input logic [NUM_W-1:0]  num,
		input logic [ADDR_W-1:0] ofs,
		input logic [ADDR_W-1:0] rva,
		input logic [ADDR_W-1:0] base,
		input logic [NAME_W-1:0] nm
	);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.section_number <= num;
		req_ch.section_offset <= ofs;
		req_ch.lookup_rva     <= rva;
		req_ch.section_base   <= base;
		req_ch.section_name   <= nm;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		act_count[act]++;
		// follow the table so later queries can hit real entries
		if (act == ACT_CLEAR) begin
			sh_n = 0;
		end else if (act == ACT_APPEND) begin
			if (sh_n < MAX_SECTIONS) begin
				sh_base[sh_n] = base;
				sh_name[sh_n] = nm;
				sh_n++;
			end else begin
				full_appends++;
			end
		end
	endtask

	// a query aimed mostly at entries in the table, with some misses and noise
	task automatic send_query();
		int unsigned       pick;
		int unsigned       k;
		logic [NUM_W-1:0]  num;
		logic [ADDR_W-1:0] rva;
		logic [NAME_W-1:0] nm;
		pick = $urandom_range(0, 9);
		k    = (sh_n > 0) ? $urandom_range(0, sh_n - 1) : 0;
		if (pick < 3) begin
			case ($urandom_range(0, 5))
			0: num = 8'($urandom);
			1: num = 8'(sh_n + 1);
			default: num = (sh_n > 0) ? 8'(k + 1) : 8'($urandom);
			endcase
			send_item(ACT_XLATE, num,
				$urandom_range(0, 1) ? $urandom : ADDR_W'($urandom_range(0, 'hFFF)),
				$urandom, $urandom, {$urandom, $urandom});
		end else if (pick < 6) begin
			case ($urandom_range(0, 3))
			0: rva = $urandom;
			1: rva = (sh_n > 0) ? sh_base[k] - 1 : $urandom;
			default: rva = (sh_n > 0) ? sh_base[k] + $urandom_range(0, 'h3000) : $urandom;
			endcase
			send_item(ACT_ADDR, 8'($urandom), $urandom, rva, $urandom, {$urandom, $urandom});
		end else if (pick < 9) begin
			nm = (sh_n > 0 && $urandom_range(0, 3) != 0) ? scramble_tail(sh_name[k])
				: pick_name();
			send_item(ACT_FIND, 8'($urandom), $urandom, $urandom, $urandom, nm);
		end else if ($urandom_range(0, 1)) begin
			send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, pick_base(), pick_name());
		end else begin
			send_item(ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
				8'($urandom), $urandom, $urandom, $urandom, {$urandom, $urandom});
		end
	endtask

	// well-formed use: clear, fill, then a run of queries
	task automatic run_session(input bit fill);
		int unsigned n_app;
		int unsigned n_q;
		tx_quiet = ($urandom_range(0, 5) == 0);
		send_item(ACT_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, {$urandom, $urandom});
		// a fill session runs up to or past capacity so that full-table appends can occur
		if (fill) begin
			n_app = $urandom_range(MAX_SECTIONS - 2, MAX_SECTIONS + 4);
			fill_sessions++;
		end else begin
			n_app = $urandom_range(1, 12);
		end
		for (int unsigned i = 0; i < n_app; i++)
			send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, pick_base(), pick_name());
		n_q = $urandom_range(6, 24);
		for (int unsigned i = 0; i < n_q; i++)
			send_query();
	endtask

	// raw noise: any action code, every field fully random
	task automatic run_noise();
		int unsigned n;
		tx_quiet = ($urandom_range(0, 3) == 0);
		n = $urandom_range(5, 15);
		for (int unsigned i = 0; i < n; i++)
			send_item(ACT_W'($urandom_range(0, 7)), 8'($urandom), $urandom, $urandom,
				$urandom, {$urandom, $urandom});
	endtask

	// every input known from time zero; reset is applied once, at the start
	initial begin
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= ACT_CLEAR;
		req_ch.section_number <= '0;
		req_ch.section_offset <= '0;
		req_ch.lookup_rva     <= '0;
		req_ch.section_base   <= '0;
		req_ch.section_name   <= '0;
		rsp_ch.ready          <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// response side: random stall per response, quiet stretches, and one long
	// hold-off while requests keep coming so the block backs up into its input
	initial begin
		int unsigned stall;
		rx_count = 0;
		rx_quiet = 1'b0;
		held     = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_count % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (rx_count == HOLD_AT && !held) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			rx_count++;
		end
	end

	// watchdog: any stretch without a handshake on either side this long is a hang
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
				idle_cycles, pending);
			$display("** section_address_map: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned n_directed;
		sent          = 0;
		full_appends  = 0;
		fill_sessions = 0;
		sh_n          = 0;
		tx_quiet      = 1'b0;
		foreach (act_count[i])
			act_count[i] = 0;
		do @(posedge clk); while (!arst_n);

		// directed part
		// queries on an empty table all miss
		send_item(ACT_ADDR, 8'h00, '0, 32'hFFFF_FFFF, $urandom, '0);
		send_item(ACT_FIND, 8'h00, '0, '0, $urandom, '0);
		send_item(ACT_XLATE, 8'h01, '0, '0, $urandom, '0);
		// five sections: extreme bases, a repeated base and name, empty and
		// unterminated names, junk after a terminator
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'h0000_1000,
			str_name(".text"));
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'h0000_0000, '1);
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'hFFFF_FFFF, '0);
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'h0000_1000,
			str_name(".text"));
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'h8000_0000,
			scramble_tail(str_name(".data")));
		// invalid numbers: zero, one past the count, the top of the field
		send_item(ACT_XLATE, 8'd0, $urandom, $urandom, $urandom, {$urandom, $urandom});
		send_item(ACT_XLATE, 8'd6, $urandom, $urandom, $urandom, {$urandom, $urandom});
		send_item(ACT_XLATE, 8'd255, $urandom, $urandom, $urandom, {$urandom, $urandom});
		// base plus offset wrapping past 32 bits, and an all-ones result that is valid
		send_item(ACT_XLATE, 8'd3, 32'h0000_0001, $urandom, $urandom, {$urandom, $urandom});
		send_item(ACT_XLATE, 8'd2, 32'hFFFF_FFFF, $urandom, $urandom, {$urandom, $urandom});
		send_item(ACT_XLATE, 8'd5, 32'h7FFF_FFFF, $urandom, $urandom, {$urandom, $urandom});
		// address lookups: tie on equal bases, exact top base, nearest below
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'h0000_1000, $urandom, '0);
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'hFFFF_FFFF, $urandom, '0);
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'hFFFF_FFFE, $urandom, '0);
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'h0000_0FFF, $urandom, '0);
		// name lookups: duplicate names, empty name, unterminated name, miss
		send_item(ACT_FIND, 8'($urandom), $urandom, $urandom, $urandom,
			scramble_tail(str_name(".text")));
		send_item(ACT_FIND, 8'($urandom), $urandom, $urandom, $urandom, '0);
		send_item(ACT_FIND, 8'($urandom), $urandom, $urandom, $urandom, '1);
		send_item(ACT_FIND, 8'($urandom), $urandom, $urandom, $urandom, str_name("nothere"));
		// unimplemented action codes
		for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
			send_item(ACT_W'(a), 8'($urandom), $urandom, $urandom, $urandom,
				{$urandom, $urandom});
		// clear empties the table; then an offset of all ones is still a hit
		send_item(ACT_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, {$urandom, $urandom});
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'h0000_0000, $urandom, '0);
		send_item(ACT_APPEND, 8'($urandom), $urandom, $urandom, 32'h0000_0000, str_name("x"));
		send_item(ACT_ADDR, 8'($urandom), $urandom, 32'hFFFF_FFFF, $urandom, '0);
		n_directed = sent;

		// random part: the first session fills the table up to or past capacity,
		// then mostly well-formed sessions with some raw noise between them
		run_session(1'b1);
		while (sent - n_directed < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0)
				run_session($urandom_range(0, 9) == 0);
			else
				run_noise();
		end
		req_ch.valid <= 1'b0;

		// drain: the checker count is registered and lags the last request
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests: %0d clear, %0d append (%0d on a full table), %0d translate,",
			sent, act_count[ACT_CLEAR], act_count[ACT_APPEND], full_appends,
			act_count[ACT_XLATE]);
		$display("%0d address, %0d name, %0d unused codes; %0d fill sessions, %0d responses checked",
			act_count[ACT_ADDR], act_count[ACT_FIND],
			act_count[5] + act_count[6] + act_count[7], fill_sessions, checked);
		if (fail_count == 0)
			$display("** section_address_map: PASSED **");
		else
			$display("** section_address_map: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/sam_pkg.sv
hw/rtl/sam_if.sv
hw/rtl/sam_ram.sv
hw/rtl/section_address_map.sv
tb/section_address_map_checker.sv
tb/section_address_map_tb.sv
